>>> hw/rtl/small_matrix_inverse_macros.svh
// assertion macros for the small matrix inverse block
// used by small_matrix_inverse.sv; no other dependencies
`ifndef SMALL_MATRIX_INVERSE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_MACROS_SVH

`ifndef SYNTHESIS
`define SMI_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("smi assertion failed");
`define SMI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("smi assertion failed");
`else
`define SMI_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define SMI_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> hw/rtl/smi_pkg.sv
// types and constants for the small matrix inverse block
// no dependencies
package smi_pkg;

  localparam int NE   = 9;   // matrix elements
  localparam int EW   = 32;  // element width, q16.16
  localparam int CW   = 64;  // cofactor width
  localparam int D2W  = 65;  // 2x2 determinant width
  localparam int DW   = 97;  // 3x3 determinant width, signed
  localparam int MW   = 96;  // determinant magnitude width
  localparam int RW   = 97;  // divider remainder width
  localparam int NDIV = 32;  // quotient bits, one per divider stage

  typedef logic [3:0] idx_t;

  // cofactor k = a[PA]*a[PB] - a[NA]*a[NB]
  localparam idx_t CF_PA [NE] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t CF_PB [NE] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t CF_NA [NE] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t CF_NB [NE] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic             size_mode;
    logic signed [31:0] mat_0;
    logic signed [31:0] mat_1;
    logic signed [31:0] mat_2;
    logic signed [31:0] mat_3;
    logic signed [31:0] mat_4;
    logic signed [31:0] mat_5;
    logic signed [31:0] mat_6;
    logic signed [31:0] mat_7;
    logic signed [31:0] mat_8;
  } in_t;

  typedef struct packed {
    logic             singular;
    logic signed [31:0] inv_0;
    logic signed [31:0] inv_1;
    logic signed [31:0] inv_2;
    logic signed [31:0] inv_3;
    logic signed [31:0] inv_4;
    logic signed [31:0] inv_5;
    logic signed [31:0] inv_6;
    logic signed [31:0] inv_7;
    logic signed [31:0] inv_8;
  } out_t;

endpackage

>>> hw/rtl/small_matrix_inverse.sv
// small_matrix_inverse: 2x2 / 3x3 signed q16.16 inverse by exact adjugate
// and determinant, fully pipelined; 32-stage restoring divider per element
// throughput: one matrix per cycle; busy is always low and results are
// never held off, set by the one-quotient-bit-per-stage divider chain
// reset: synchronous active-low rst_n clears all stage valid bits
`include "small_matrix_inverse_macros.svh"

module small_matrix_inverse (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  smi_pkg::in_t in_data,
  output logic         out_valid,
  output smi_pkg::out_t out_data
);
  import smi_pkg::*;

  logic signed [EW-1:0] a [NE];

  // stage 1: products
  logic                 s1_vld_r;
  logic                 s1_size_r;
  logic signed [CW-1:0] s1_pp_r [NE];
  logic signed [CW-1:0] s1_pn_r [NE];
  logic signed [CW-1:0] s1_d2a_r, s1_d2b_r;
  logic signed [EW-1:0] s1_a_r [4];

  // stage 2: cofactors
  logic                 s2_vld_r;
  logic                 s2_size_r;
  logic signed [CW-1:0] s2_c_r [NE];
  logic signed [D2W-1:0] s2_det2_r;
  logic signed [EW-1:0] s2_a_r [3];

  // stage 3: determinant partial products
  logic                 s3_vld_r;
  logic                 s3_size_r;
  logic signed [CW-1:0] s3_c_r [NE];
  logic signed [D2W-1:0] s3_det2_r;
  logic signed [63:0]   s3_ph_r [3];
  logic signed [64:0]   s3_pl_r [3];

  // stage 4: determinant terms
  logic                 s4_vld_r;
  logic                 s4_size_r;
  logic signed [CW-1:0] s4_c_r [NE];
  logic signed [D2W-1:0] s4_det2_r;
  logic signed [DW-1:0] s4_t_r [3];

  // stage 5: determinant
  logic                 s5_vld_r;
  logic signed [CW-1:0] s5_c_r [NE];
  logic signed [DW-1:0] s5_det_r;

  // stage 6: magnitudes
  logic                 s6_vld_r;
  logic [CW-1:0]        s6_cmag_r [NE];
  logic [MW-1:0]        s6_dmag_r;
  logic [NE-1:0]        s6_neg_r;
  logic                 s6_sing_r;

  // divider chain
  logic                 dv_vld_r  [NDIV+1];
  logic                 dv_sing_r [NDIV+1];
  logic [NE-1:0]        dv_neg_r  [NDIV+1];
  logic [NE-1:0]        dv_ovf_r  [NDIV+1];
  logic [EW-1:0]        dv_q_r    [NDIV+1][NE];
  logic [RW-1:0]        dv_rem_r  [NDIV][NE];
  logic [MW-1:0]        dv_dmag_r [NDIV];

  logic                 out_valid_r;
  out_t                 out_data_r, out_data_nxt;
  logic [EW-1:0]        res [NE];

  assign busy = 1'b0;

  always_comb begin
    a[0] = in_data.mat_0;
    a[1] = in_data.mat_1;
    a[2] = in_data.mat_2;
    a[3] = in_data.mat_3;
    a[4] = in_data.mat_4;
    a[5] = in_data.mat_5;
    a[6] = in_data.mat_6;
    a[7] = in_data.mat_7;
    a[8] = in_data.mat_8;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      dv_vld_r[0] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= start & ~busy;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      dv_vld_r[0] <= s6_vld_r;
      out_valid_r <= dv_vld_r[NDIV];
    end
  end

  // front stages, payload only
  always_ff @(posedge clk) begin
    for (int k = 0; k < NE; k++) begin
      s1_pp_r[k] <= CW'(a[CF_PA[k]]) * CW'(a[CF_PB[k]]);
      s1_pn_r[k] <= CW'(a[CF_NA[k]]) * CW'(a[CF_NB[k]]);
    end
    s1_d2a_r  <= CW'(a[0]) * CW'(a[3]);
    s1_d2b_r  <= CW'(a[1]) * CW'(a[2]);
    for (int k = 0; k < 4; k++) s1_a_r[k] <= a[k];
    s1_size_r <= in_data.size_mode;

    if (s1_size_r) begin
      for (int k = 0; k < NE; k++) s2_c_r[k] <= s1_pp_r[k] - s1_pn_r[k];
    end else begin
      for (int k = 0; k < NE; k++) s2_c_r[k] <= '0;
      s2_c_r[0] <= CW'(s1_a_r[3]);
      s2_c_r[1] <= -CW'(s1_a_r[1]);
      s2_c_r[2] <= -CW'(s1_a_r[2]);
      s2_c_r[3] <= CW'(s1_a_r[0]);
    end
    s2_det2_r <= D2W'(s1_d2a_r) - D2W'(s1_d2b_r);
    for (int k = 0; k < 3; k++) s2_a_r[k] <= s1_a_r[k];
    s2_size_r <= s1_size_r;

    // a * c split into signed high and unsigned low halves of c
    for (int k = 0; k < 3; k++) begin
      s3_ph_r[k] <= 64'(s2_a_r[k]) * 64'($signed(s2_c_r[3*k][CW-1:32]));
      s3_pl_r[k] <= 65'(s2_a_r[k]) * $signed({1'b0, s2_c_r[3*k][31:0]});
    end
    s3_c_r    <= s2_c_r;
    s3_det2_r <= s2_det2_r;
    s3_size_r <= s2_size_r;

    for (int k = 0; k < 3; k++)
      s4_t_r[k] <= DW'($signed({s3_ph_r[k], 32'b0})) + DW'(s3_pl_r[k]);
    s4_c_r    <= s3_c_r;
    s4_det2_r <= s3_det2_r;
    s4_size_r <= s3_size_r;

    if (s4_size_r) s5_det_r <= s4_t_r[0] + s4_t_r[1] + s4_t_r[2];
    else           s5_det_r <= {{(DW-D2W){s4_det2_r[D2W-1]}}, s4_det2_r};
    s5_c_r <= s4_c_r;
  end

  // magnitudes, signs and divider setup
  always_ff @(posedge clk) begin : mag_blk
    logic signed [DW-1:0] dneg;
    dneg = -s5_det_r;
    s6_dmag_r <= s5_det_r[DW-1] ? dneg[MW-1:0] : s5_det_r[MW-1:0];
    s6_sing_r <= (s5_det_r == '0);
    for (int k = 0; k < NE; k++) begin
      s6_cmag_r[k] <= s5_c_r[k][CW-1] ? -s5_c_r[k] : s5_c_r[k];
      s6_neg_r[k]  <= s5_c_r[k][CW-1] ^ s5_det_r[DW-1];
    end

    // quotient fits 32 bits only when |c| < |det|
    for (int k = 0; k < NE; k++) begin
      dv_ovf_r[0][k] <= {{(MW-CW){1'b0}}, s6_cmag_r[k]} >= s6_dmag_r;
      dv_rem_r[0][k] <= {{(RW-CW){1'b0}}, s6_cmag_r[k]};
      dv_q_r[0][k]   <= '0;
    end
    dv_neg_r[0]  <= s6_neg_r;
    dv_sing_r[0] <= s6_sing_r;
    dv_dmag_r[0] <= s6_dmag_r;
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    logic [RW-1:0] r2  [NE];
    logic [RW-1:0] dif [NE];
    logic [NE-1:0] qb;

    always_comb begin
      for (int k = 0; k < NE; k++) begin
        r2[k]  = {dv_rem_r[g][k][RW-2:0], 1'b0};
        dif[k] = r2[k] - {1'b0, dv_dmag_r[g]};
        qb[k]  = (r2[k] >= {1'b0, dv_dmag_r[g]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[g+1] <= 1'b0;
      else        dv_vld_r[g+1] <= dv_vld_r[g];
      for (int k = 0; k < NE; k++)
        dv_q_r[g+1][k] <= {dv_q_r[g][k][EW-2:0], qb[k]};
      dv_neg_r[g+1]  <= dv_neg_r[g];
      dv_ovf_r[g+1]  <= dv_ovf_r[g];
      dv_sing_r[g+1] <= dv_sing_r[g];
    end

    if (g < NDIV-1) begin : g_fwd
      always_ff @(posedge clk) begin
        for (int k = 0; k < NE; k++)
          dv_rem_r[g+1][k] <= qb[k] ? dif[k] : r2[k];
        dv_dmag_r[g+1] <= dv_dmag_r[g];
      end
    end
  end

  // sign, saturation and singular zeroing
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (dv_sing_r[NDIV]) begin
        res[k] = '0;
      end else if (dv_ovf_r[NDIV][k] || dv_q_r[NDIV][k][EW-1]) begin
        res[k] = dv_neg_r[NDIV][k] ? SAT_NEG : SAT_POS;
      end else begin
        res[k] = dv_neg_r[NDIV][k] ? -dv_q_r[NDIV][k] : dv_q_r[NDIV][k];
      end
    end
    out_data_nxt.singular = dv_sing_r[NDIV];
    out_data_nxt.inv_0    = res[0];
    out_data_nxt.inv_1    = res[1];
    out_data_nxt.inv_2    = res[2];
    out_data_nxt.inv_3    = res[3];
    out_data_nxt.inv_4    = res[4];
    out_data_nxt.inv_5    = res[5];
    out_data_nxt.inv_6    = res[6];
    out_data_nxt.inv_7    = res[7];
    out_data_nxt.inv_8    = res[8];
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SMI_ASSERT_NEXT(a_start_enters, clk, rst_n, start, s1_vld_r)
  `SMI_ASSERT_IMPLY(a_out_from_div, clk, rst_n, out_valid, $past(dv_vld_r[NDIV]))
  `SMI_ASSERT_IMPLY(a_sing_zero, clk, rst_n, out_valid && out_data.singular,
    out_data.inv_0 == '0 && out_data.inv_1 == '0 && out_data.inv_2 == '0 &&
    out_data.inv_3 == '0 && out_data.inv_4 == '0 && out_data.inv_5 == '0 &&
    out_data.inv_6 == '0 && out_data.inv_7 == '0 && out_data.inv_8 == '0)

endmodule
